>>> rtl/ksenc_pkg.sv
// ----------------------------------------------------------------------------
// Key escape sequence encoder package
// Shared widths, register indexes, byte constants and the key class type.
// ----------------------------------------------------------------------------
package ksenc_pkg;

  localparam int unsigned KeyW     = 5;
  localparam int unsigned ModW     = 3;
  localparam int unsigned FlagsW   = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned MaxSeq   = 8;
  localparam int unsigned PosW     = $clog2(MaxSeq);
  localparam int unsigned LenW     = $clog2(MaxSeq + 1);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCursorApp = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFlags     = 1'b1;

  // Protocol flag bits.
  localparam int unsigned FlagDisambig = 0;
  localparam int unsigned FlagAllKeys  = 3;

  // Byte values.
  localparam logic [7:0] ChEsc    = 8'h1B;
  localparam logic [7:0] ChBrack  = 8'h5B;
  localparam logic [7:0] ChO      = 8'h4F;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChZ      = 8'h5A;
  localparam logic [7:0] ChTilde  = 8'h7E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChOne    = 8'h31;

  // Key codes used for classification.
  localparam logic [KeyW-1:0] KeyEnter  = 5'd1;
  localparam logic [KeyW-1:0] KeyTab    = 5'd2;
  localparam logic [KeyW-1:0] KeyBksp   = 5'd3;
  localparam logic [KeyW-1:0] KeyEsc    = 5'd4;
  localparam logic [KeyW-1:0] KeyUp     = 5'd5;
  localparam logic [KeyW-1:0] KeyEnd    = 5'd10;
  localparam logic [KeyW-1:0] KeyIns    = 5'd11;
  localparam logic [KeyW-1:0] KeyPgDn   = 5'd14;
  localparam logic [KeyW-1:0] KeyF1     = 5'd15;
  localparam logic [KeyW-1:0] KeyF4     = 5'd18;
  localparam logic [KeyW-1:0] KeyF5     = 5'd19;
  localparam logic [KeyW-1:0] KeyF12    = 5'd26;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CSI_U,
    KIND_BACKTAB,
    KIND_LEGACY,
    KIND_CURSOR,
    KIND_SS3,
    KIND_TILDE
  } kind_e;

  typedef logic [7:0] byte_t;

endpackage

>>> rtl/key_escape_sequence_encoder_top.sv
// ----------------------------------------------------------------------------
// Key escape sequence encoder
// Turns one key event into the terminal byte sequence for that key.
// ----------------------------------------------------------------------------
// Usage:
//   A request (key_code_i, modifiers_i) is taken at a rising edge with start_i
//   high and busy_o low. Its bytes leave on out_byte_o one per cycle, each
//   marked by out_valid_o for exactly one cycle, the final one also by
//   last_byte_o. Keys without a sequence produce no bytes at all.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i: index
//   0 is the cursor application mode, index 1 the keyboard protocol flags. The
//   user must write it only while idle; the block itself does not enforce this.
// Pipeline and throughput:
//   Three register stages (classify, look up, assemble) feed a byte
//   serialiser, which sends one output byte per cycle; a sequence has 1 to
//   8 bytes. Requests may be issued back to back while earlier ones are
//   still in flight; busy_o rises only when every stage holds a request
//   waiting for the serialiser.
// Reset:
//   rst_ni clears all valid bits and both configuration registers. The
//   receiver cannot stall, so bytes are never held back once emitted.
// ----------------------------------------------------------------------------
module key_escape_sequence_encoder_top
  import ksenc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [KeyW-1:0]     key_code_i,
  input  logic [ModW-1:0]     modifiers_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                last_byte_o
);

  // Configuration registers.
  logic              cursor_app_q;
  logic [FlagsW-1:0] flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_app_q <= 1'b0;
      flags_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCursorApp: cursor_app_q <= cfg_data_i[0];
        RegFlags:     flags_q      <= cfg_data_i[FlagsW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake chain.
  logic a_valid_q, b_valid_q, c_valid_q, ser_valid_q;
  logic a_ready, b_ready, c_ready, ser_free;
  logic accept;
  logic [PosW-1:0] ser_idx_q, ser_last_q;
  logic [LenW-1:0] c_len_q;

  assign ser_free = !ser_valid_q || (ser_idx_q == ser_last_q);
  assign c_ready  = !c_valid_q || ser_free || (c_len_q == '0);
  assign b_ready  = !b_valid_q || c_ready;
  assign a_ready  = !a_valid_q || b_ready;
  assign busy_o   = !a_ready;
  assign accept   = start_i && a_ready;

  // --------------------------------------------------------------------------
  // Stage A: classify the key.
  // --------------------------------------------------------------------------
  kind_e            a_kind_d, a_kind_q;
  logic [KeyW-1:0]  a_key_q;
  logic [ModW-1:0]  a_mods_q;
  logic             in_modded, route_csi_u;

  assign in_modded   = (modifiers_i != '0);
  assign route_csi_u = flags_q[FlagAllKeys] || (flags_q[FlagDisambig] && in_modded);

  always_comb begin
    a_kind_d = KIND_NONE;
    if (key_code_i >= KeyEnter && key_code_i <= KeyEsc) begin
      if (route_csi_u) begin
        a_kind_d = KIND_CSI_U;
      end else if (key_code_i == KeyTab && modifiers_i[0]) begin
        a_kind_d = KIND_BACKTAB;
      end else begin
        a_kind_d = KIND_LEGACY;
      end
    end else if (key_code_i >= KeyUp && key_code_i <= KeyEnd) begin
      a_kind_d = KIND_CURSOR;
    end else if ((key_code_i >= KeyIns && key_code_i <= KeyPgDn) ||
                 (key_code_i >= KeyF5 && key_code_i <= KeyF12)) begin
      a_kind_d = KIND_TILDE;
    end else if (key_code_i >= KeyF1 && key_code_i <= KeyF4) begin
      a_kind_d = KIND_SS3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_kind_q <= a_kind_d;
      a_key_q  <= key_code_i;
      a_mods_q <= modifiers_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: look up numbers, letters and prefixes.
  // --------------------------------------------------------------------------
  logic       b_empty_d, b_empty_q;
  logic       b_legacy_d, b_legacy_q;
  byte_t      b_lbyte_d, b_lbyte_q;
  byte_t      b_second_d, b_second_q;
  logic [1:0] b_ndig_d, b_ndig_q;
  byte_t      b_dig_d [3];
  byte_t      b_dig_q [3];
  logic       b_has_mod_d, b_has_mod_q;
  byte_t      b_modch_d, b_modch_q;
  byte_t      b_final_d, b_final_q;

  logic [1:0] k_ndig;
  byte_t      k_dig [3];
  byte_t      k_letter;
  byte_t      k_legacy;
  logic       a_modded;

  assign a_modded = (a_mods_q != '0);

  // Decimal parameter of each key, most significant digit first.
  always_comb begin
    k_ndig   = 2'd0;
    k_dig[0] = ChZero;
    k_dig[1] = ChZero;
    k_dig[2] = ChZero;
    unique case (a_key_q)
      5'd1:  begin k_ndig = 2'd2; k_dig[0] = 8'h31; k_dig[1] = 8'h33; end
      5'd2:  begin k_ndig = 2'd1; k_dig[0] = 8'h39; end
      5'd3:  begin
        k_ndig = 2'd3; k_dig[0] = 8'h31; k_dig[1] = 8'h32; k_dig[2] = 8'h37;
      end
      5'd4:  begin k_ndig = 2'd2; k_dig[0] = 8'h32; k_dig[1] = 8'h37; end
      5'd11: begin k_ndig = 2'd1; k_dig[0] = 8'h32; end
      5'd12: begin k_ndig = 2'd1; k_dig[0] = 8'h33; end
      5'd13: begin k_ndig = 2'd1; k_dig[0] = 8'h35; end
      5'd14: begin k_ndig = 2'd1; k_dig[0] = 8'h36; end
      5'd19: begin k_ndig = 2'd2; k_dig[0] = 8'h31; k_dig[1] = 8'h35; end
      5'd20: begin k_ndig = 2'd2; k_dig[0] = 8'h31; k_dig[1] = 8'h37; end
      5'd21: begin k_ndig = 2'd2; k_dig[0] = 8'h31; k_dig[1] = 8'h38; end
      5'd22: begin k_ndig = 2'd2; k_dig[0] = 8'h31; k_dig[1] = 8'h39; end
      5'd23: begin k_ndig = 2'd2; k_dig[0] = 8'h32; k_dig[1] = 8'h30; end
      5'd24: begin k_ndig = 2'd2; k_dig[0] = 8'h32; k_dig[1] = 8'h31; end
      5'd25: begin k_ndig = 2'd2; k_dig[0] = 8'h32; k_dig[1] = 8'h33; end
      5'd26: begin k_ndig = 2'd2; k_dig[0] = 8'h32; k_dig[1] = 8'h34; end
      default: ;
    endcase
  end

  always_comb begin
    k_letter = 8'h41;
    k_legacy = 8'h0D;
    unique case (a_key_q)
      5'd1:  k_legacy = 8'h0D;
      5'd2:  k_legacy = 8'h09;
      5'd3:  k_legacy = 8'h7F;
      5'd4:  k_legacy = 8'h1B;
      5'd5:  k_letter = 8'h41;
      5'd6:  k_letter = 8'h42;
      5'd7:  k_letter = 8'h43;
      5'd8:  k_letter = 8'h44;
      5'd9:  k_letter = 8'h48;
      5'd10: k_letter = 8'h46;
      5'd15: k_letter = 8'h50;
      5'd16: k_letter = 8'h51;
      5'd17: k_letter = 8'h52;
      5'd18: k_letter = 8'h53;
      default: ;
    endcase
  end

  always_comb begin
    b_empty_d   = 1'b0;
    b_legacy_d  = 1'b0;
    b_lbyte_d   = k_legacy;
    b_second_d  = ChBrack;
    b_ndig_d    = 2'd0;
    b_dig_d[0]  = k_dig[0];
    b_dig_d[1]  = k_dig[1];
    b_dig_d[2]  = k_dig[2];
    b_has_mod_d = 1'b0;
    b_modch_d   = ChOne + {5'd0, a_mods_q};
    b_final_d   = ChU;
    unique case (a_kind_q)
      KIND_NONE: b_empty_d = 1'b1;
      KIND_CSI_U: begin
        b_ndig_d    = k_ndig;
        b_has_mod_d = a_modded;
      end
      KIND_BACKTAB: b_final_d = ChZ;
      KIND_LEGACY:  b_legacy_d = 1'b1;
      KIND_CURSOR, KIND_SS3: begin
        b_final_d = k_letter;
        if (a_modded) begin
          // Modified form is CSI 1 ; mod letter.
          b_ndig_d    = 2'd1;
          b_dig_d[0]  = ChOne;
          b_has_mod_d = 1'b1;
        end else if (a_kind_q == KIND_SS3 || cursor_app_q) begin
          b_second_d = ChO;
        end
      end
      KIND_TILDE: begin
        b_ndig_d    = k_ndig;
        b_has_mod_d = a_modded;
        b_final_d   = ChTilde;
      end
      default: b_empty_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_empty_q   <= b_empty_d;
      b_legacy_q  <= b_legacy_d;
      b_lbyte_q   <= b_lbyte_d;
      b_second_q  <= b_second_d;
      b_ndig_q    <= b_ndig_d;
      b_dig_q     <= b_dig_d;
      b_has_mod_q <= b_has_mod_d;
      b_modch_q   <= b_modch_d;
      b_final_q   <= b_final_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: assemble the byte string and its length.
  // --------------------------------------------------------------------------
  byte_t           c_seq_d [MaxSeq];
  byte_t           c_seq_q [MaxSeq];
  logic [LenW-1:0] c_len_d;
  logic [PosW-1:0] pos;

  always_comb begin
    for (int i = 0; i < MaxSeq; i++) begin
      c_seq_d[i] = ChZero;
    end
    pos     = '0;
    c_len_d = '0;
    if (b_empty_q) begin
      c_len_d = '0;
    end else if (b_legacy_q) begin
      c_seq_d[0] = b_lbyte_q;
      c_len_d    = LenW'(1);
    end else begin
      c_seq_d[0] = ChEsc;
      c_seq_d[1] = b_second_q;
      pos        = PosW'(2);
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < b_ndig_q) begin
          c_seq_d[pos] = b_dig_q[i];
          pos          = pos + PosW'(1);
        end
      end
      if (b_has_mod_q) begin
        c_seq_d[pos]            = ChSemi;
        c_seq_d[pos + PosW'(1)] = b_modch_q;
        pos                     = pos + PosW'(2);
      end
      c_seq_d[pos] = b_final_q;
      c_len_d      = {1'b0, pos} + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      c_len_q   <= '0;
    end else if (c_ready) begin
      c_valid_q <= b_valid_q;
      if (b_valid_q) begin
        c_len_q <= c_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_seq_q <= c_seq_d;
    end
  end

  // --------------------------------------------------------------------------
  // Serialiser: one byte per cycle. Empty sequences are dropped in stage C.
  // --------------------------------------------------------------------------
  byte_t ser_seq_q [MaxSeq];
  logic  ser_load;

  assign ser_load = ser_free && c_valid_q && (c_len_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_idx_q   <= '0;
      ser_last_q  <= '0;
    end else if (!ser_free) begin
      ser_idx_q <= ser_idx_q + PosW'(1);
    end else if (ser_load) begin
      ser_valid_q <= 1'b1;
      ser_idx_q   <= '0;
      ser_last_q  <= PosW'(c_len_q - LenW'(1));
    end else begin
      ser_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_seq_q <= c_seq_q;
    end
  end

  assign out_valid_o = ser_valid_q;
  assign out_byte_o  = ser_seq_q[ser_idx_q];
  assign last_byte_o = ser_valid_q && (ser_idx_q == ser_last_q);

endmodule

>>> rtl/ksenc_checker.sv
// ----------------------------------------------------------------------------
// Key escape sequence encoder checker
// Port-level properties of the byte stream and the request handshake.
// ----------------------------------------------------------------------------
module ksenc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy_o,
  input logic out_valid_o,
  input logic last_byte_o
);

  // A sequence never ends without its final byte being marked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(last_byte_o))
    else $error("byte stream stopped before the final byte");

  // Bytes of one sequence follow each other without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_byte_o) |=> out_valid_o)
    else $error("gap inside a byte sequence");

  // The last marker only appears on a valid byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> out_valid_o)
    else $error("last marker without a valid byte");

  // Requests are only held off while bytes are flowing out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> out_valid_o)
    else $error("busy while the output is idle");

endmodule

bind key_escape_sequence_encoder_top ksenc_checker u_ksenc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy_o      (busy_o),
  .out_valid_o (out_valid_o),
  .last_byte_o (last_byte_o)
);

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Key escape sequence encoder testbench
// Sends key requests through the start/busy handshake and checks every emitted
// byte and its last marker against a local encoder kept in step with the
// configuration writes. A directed set comes first, then random keys under
// several register settings and sender idling patterns.
// ----------------------------------------------------------------------------
module tb_top
  import ksenc_pkg::*;
;

  localparam int unsigned SettleCycles = 12;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomKeys   = 146;

  typedef struct packed {
    byte_t data;
    logic  last;
  } key_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [KeyW-1:0]     key_code_i = '0;
  logic [ModW-1:0]     modifiers_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                out_valid_o;
  logic [7:0]          out_byte_o;
  logic                last_byte_o;

  key_byte_t           pending_bytes[$];
  logic                app_cursor_q = 1'b0;
  logic [FlagsW-1:0]   proto_flags_q = '0;
  int unsigned         gap_pct = 0;
  int unsigned         fail_count = 0;
  int unsigned         cycle_count = 0;

  key_escape_sequence_encoder_top dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- encoder
  function automatic void emit(input byte_t b);
    pending_bytes.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void emit_dec(input int unsigned v);
    if (v >= 100) emit(ChZero + byte_t'((v / 100) % 10));
    if (v >= 10) emit(ChZero + byte_t'((v / 10) % 10));
    emit(ChZero + byte_t'(v % 10));
  endfunction

  // Modified keys carry ";mod" where mod is one more than the modifier bits.
  function automatic void emit_mod_suffix(input logic [ModW-1:0] m);
    emit(ChSemi);
    emit_dec(int'(m) + 1);
  endfunction

  function automatic void encode_key(input logic [KeyW-1:0] k, input logic [ModW-1:0] m);
    int unsigned before_n;
    int unsigned num;
    byte_t       plain;
    byte_t       letter;
    logic        csi_u;
    before_n = pending_bytes.size();
    if (k >= KeyEnter && k <= KeyEsc) begin
      case (k)
        KeyEnter: begin num = 13;  plain = 8'h0D; end
        KeyTab:   begin num = 9;   plain = 8'h09; end
        KeyBksp:  begin num = 127; plain = 8'h7F; end
        default:  begin num = 27;  plain = ChEsc; end
      endcase
      csi_u = proto_flags_q[FlagAllKeys] || (proto_flags_q[FlagDisambig] && m != '0);
      if (csi_u) begin
        emit(ChEsc);
        emit(ChBrack);
        emit_dec(num);
        if (m != '0) emit_mod_suffix(m);
        emit(ChU);
      end else if (k == KeyTab && m[0]) begin
        emit(ChEsc);
        emit(ChBrack);
        emit(ChZ);
      end else begin
        emit(plain);
      end
    end else if (k >= KeyUp && k <= KeyEnd) begin
      case (k - KeyUp)
        0:       letter = "A";
        1:       letter = "B";
        2:       letter = "C";
        3:       letter = "D";
        4:       letter = "H";
        default: letter = "F";
      endcase
      emit(ChEsc);
      if (m == '0) begin
        emit(app_cursor_q ? ChO : ChBrack);
      end else begin
        emit(ChBrack);
        emit(ChOne);
        emit_mod_suffix(m);
      end
      emit(letter);
    end else if ((k >= KeyIns && k <= KeyPgDn) || (k >= KeyF5 && k <= KeyF12)) begin
      case (k)
        KeyIns:        num = 2;
        KeyIns + 5'd1: num = 3;
        KeyIns + 5'd2: num = 5;
        KeyPgDn:       num = 6;
        KeyF5:         num = 15;
        KeyF5 + 5'd1:  num = 17;
        KeyF5 + 5'd2:  num = 18;
        KeyF5 + 5'd3:  num = 19;
        KeyF5 + 5'd4:  num = 20;
        KeyF5 + 5'd5:  num = 21;
        KeyF5 + 5'd6:  num = 23;
        default:       num = 24;
      endcase
      emit(ChEsc);
      emit(ChBrack);
      emit_dec(num);
      if (m != '0) emit_mod_suffix(m);
      emit(ChTilde);
    end else if (k >= KeyF1 && k <= KeyF4) begin
      // F1 to F4 use their own letters P to S, modified or not.
      letter = "P" + byte_t'(k - KeyF1);
      emit(ChEsc);
      if (m == '0) begin
        emit(ChO);
      end else begin
        emit(ChBrack);
        emit(ChOne);
        emit_mod_suffix(m);
      end
      emit(letter);
    end
    if (pending_bytes.size() > before_n) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    key_byte_t exp_b;
    if (rst_ni && out_valid_o) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte %h (last %b)", out_byte_o, last_byte_o);
        fail_count++;
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_byte_o !== exp_b.data) begin
          $error("out_byte: expected %h, got %h", exp_b.data, out_byte_o);
          fail_count++;
        end
        if (last_byte_o !== exp_b.last) begin
          $error("last_byte: expected %b, got %b", exp_b.last, last_byte_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_key(input logic [KeyW-1:0] k, input logic [ModW-1:0] m);
    // Each cycle the sender stays idle with the chosen percentage.
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    key_code_i  <= k;
    modifiers_i <= m;
    do @(posedge clk_i); while (busy_o);
    encode_key(k, m);
  endtask

  // Lets every outstanding request finish, including ones that emit nothing.
  task automatic settle();
    start_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegCursorApp) app_cursor_q = data[0];
    else proto_flags_q = data[FlagsW-1:0];
  endtask

  task automatic configure(input logic [CfgDataW-1:0] app, input logic [CfgDataW-1:0] flags);
    settle();
    write_reg(RegCursorApp, app);
    write_reg(RegFlags, flags);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_legacy_keys();
    send_key(5'd0, 3'd0);
    send_key(KeyEnter, 3'd0);
    send_key(KeyTab, 3'd0);
    send_key(KeyTab, 3'd1);
    send_key(KeyBksp, 3'd6);
    send_key(KeyEsc, 3'd0);
    send_key(KeyUp, 3'd0);
    send_key(KeyEnd, 3'd7);
    send_key(KeyIns, 3'd0);
    send_key(KeyPgDn, 3'd2);
    send_key(KeyF1, 3'd0);
    send_key(KeyF4, 3'd7);
    send_key(KeyF12, 3'd0);
    send_key(5'd31, 3'd7);
  endtask

  task automatic test_protocol_modes();
    configure(4'b0001, 4'b0001);
    send_key(KeyEnter, 3'd0);
    send_key(KeyEsc, 3'd4);
    send_key(KeyUp, 3'd0);
    send_key(KeyF1, 3'd0);
    send_key(KeyUp + 5'd3, 3'd1);
    configure(4'b1110, 4'b1111);
    send_key(KeyTab, 3'd0);
    send_key(KeyBksp, 3'd7);
    send_key(KeyTab, 3'd1);
    send_key(5'd27, 3'd0);
  endtask

  task automatic test_random_keys(input int unsigned n_keys, input int unsigned pct);
    int unsigned sent;
    int unsigned pick;
    logic [KeyW-1:0] k;
    gap_pct = pct;
    sent = 0;
    while (sent < n_keys) begin
      if (sent % 19 == 0) begin
        pick = $urandom_range(4);
        case (pick)
          0:       configure(4'($urandom), 4'b0000);
          1:       configure(4'($urandom), 4'b1111);
          default: configure(4'($urandom), 4'($urandom));
        endcase
      end
      k = 5'($urandom);
      send_key(k, 3'($urandom));
      sent++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_legacy_keys();
    test_protocol_modes();
    test_random_keys(RandomKeys / 3, 28);
    test_random_keys(RandomKeys / 3, 87);
    test_random_keys(RandomKeys - 2 * (RandomKeys / 3), 0);
    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
